FILE: rtl/core/glyph_row_blitter_macros.svh
// assertion macros for the glyph row blitter
`ifndef GLYPH_ROW_BLITTER_MACROS_SVH
`define GLYPH_ROW_BLITTER_MACROS_SVH

// same-cycle implication under reset
`define GRB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define GRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/grb_pkg.sv
// types and constants shared by the glyph row blitter
`timescale 1ns / 1ps

package grb_pkg;

    localparam int DEF_MAX_GLYPH_WIDTH = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH   = 3'd4;

    typedef struct packed {
        logic        [63:0] row_bits;
        logic        [6:0]  font_w;
        logic        [6:0]  font_h;
        logic signed [7:0]  glyph_row;
        logic signed [15:0] dest_x;
        logic signed [15:0] dest_y;
        logic signed [7:0]  first_col;
        logic signed [7:0]  col_count;
        logic        [31:0] fg_colour;
        logic        [31:0] bg_colour;
        logic               draw_fg;
        logic               draw_bg;
    } t_item;

    typedef struct packed {
        logic [23:0] pixel_index;
        logic [31:0] pixel_value;
        logic        last_write;
    } t_result;

endpackage

FILE: rtl/core/glyph_row_blitter.sv
// glyph row blitter: one glyph row in, clipped pixel writes out
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------
//  item in   | i_start, o_busy         | i_item (t_item)
//  result out| o_res_strobe            | o_result (t_result)
//  config    | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// an accepted row that draws walks n columns, n the saturated column count:
// setup does the row base multiply, walk takes one column per cycle through the shared
// clip compare and index adder, and flush moves the held write out as the final transfer.
// a row rejected up front (no flags, zero size or count, row clipped) never leaves idle.
// results leave at most one per cycle and cannot be stalled.
// reset is synchronous, active low, and restores the default clip and pitch.
`timescale 1ns / 1ps
`include "glyph_row_blitter_macros.svh"

module glyph_row_blitter #(
    parameter int MAX_GLYPH_WIDTH = grb_pkg::DEF_MAX_GLYPH_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  grb_pkg::t_item                   i_item,
    output logic                             o_res_strobe,
    output grb_pkg::t_result                 o_result,
    input  logic                             i_cfg_we,
    input  logic [grb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [grb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import grb_pkg::*;

    localparam int NW = $clog2(MAX_GLYPH_WIDTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [11:0] r_clip_x, r_clip_y;
    logic [12:0] r_clip_w, r_clip_h, r_pitch;

    logic [63:0]        r_bits;
    logic [6:0]         r_gw;
    logic               r_row_in;
    logic signed [16:0] r_x;
    logic signed [8:0]  r_col;
    logic               r_back;
    logic [NW-1:0]      r_left;
    logic [31:0]        r_fg, r_bg;
    logic               r_dfg, r_dbg;
    logic [11:0]        r_dy_rel;
    logic [23:0]        r_base;

    logic        r_pend_vld;
    logic [23:0] r_pend_idx;
    logic [31:0] r_pend_val;
    logic        r_out_vld;
    t_result     r_out;

    // accept-time checks
    logic        accept, draws;
    logic [15:0] dy_u;
    logic [13:0] y_end, x_end;
    logic [7:0]  mag;
    logic [NW-1:0] n_sat;
    logic [6:0]  gw_sat;
    logic        row_in;

    // per-column unit
    logic        x_ok, col_ok, is_fg, hit;
    logic [15:0] x_rel;
    logic [23:0] pix_idx;
    logic [31:0] pix_val;
    logic [25:0] prod;

    assign accept = i_start && (r_state == ST_IDLE);
    assign dy_u   = i_item.dest_y[15:0];
    assign y_end  = {2'b0, r_clip_y} + {1'b0, r_clip_h};
    assign draws  = (i_item.draw_fg || i_item.draw_bg)
                 && (i_item.font_w != 7'd0) && (i_item.font_h != 7'd0)
                 && (i_item.col_count != 8'sd0)
                 && !i_item.dest_y[15]
                 && (dy_u >= {4'b0, r_clip_y})
                 && (dy_u < {2'b0, y_end});
    assign mag    = i_item.col_count[7] ? 8'(-i_item.col_count) : i_item.col_count;
    assign n_sat  = (mag > 8'(MAX_GLYPH_WIDTH)) ? NW'(MAX_GLYPH_WIDTH) : mag[NW-1:0];
    assign gw_sat = (i_item.font_w > 7'(MAX_GLYPH_WIDTH)) ? 7'(MAX_GLYPH_WIDTH)
                                                          : i_item.font_w;
    assign row_in = !i_item.glyph_row[7] && (i_item.glyph_row[6:0] < i_item.font_h);

    assign x_end   = {2'b0, r_clip_x} + {1'b0, r_clip_w};
    assign x_ok    = !r_x[16] && (r_x[15:0] >= {4'b0, r_clip_x})
                  && (r_x[15:0] < {2'b0, x_end});
    assign col_ok  = r_row_in && !r_col[8] && (r_col[7:0] < {1'b0, r_gw});
    assign is_fg   = col_ok && r_bits[~r_col[5:0]];
    assign hit     = x_ok && (is_fg ? r_dfg : r_dbg);
    assign x_rel   = r_x[15:0] - {4'b0, r_clip_x};
    assign pix_idx = r_base + {8'b0, x_rel};
    assign pix_val = is_fg ? r_fg : r_bg;
    assign prod    = r_pitch * {1'b0, r_dy_rel};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && draws) n_state = ST_SETUP;
            ST_SETUP: n_state = ST_WALK;
            ST_WALK:  if (r_left == NW'(1)) n_state = ST_FLUSH;
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clip_x   <= 12'd0;
            r_clip_y   <= 12'd0;
            r_clip_w   <= 13'd0;
            r_clip_h   <= 13'd0;
            r_pitch    <= 13'd1;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CLIP_X:      r_clip_x <= i_cfg_data[11:0];
                    CFG_CLIP_Y:      r_clip_y <= i_cfg_data[11:0];
                    CFG_CLIP_WIDTH:  r_clip_w <= i_cfg_data;
                    CFG_CLIP_HEIGHT: r_clip_h <= i_cfg_data;
                    CFG_ROW_PITCH:   r_pitch  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_WALK) begin
                r_out_vld <= hit && r_pend_vld;
                if (hit) begin
                    r_pend_vld <= 1'b1;
                end
            end else if (r_state == ST_FLUSH) begin
                r_pend_vld <= 1'b0;
                r_out_vld  <= r_pend_vld;
            end else begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bits   <= i_item.row_bits;
            r_gw     <= gw_sat;
            r_row_in <= row_in;
            r_x      <= 17'(i_item.dest_x);
            r_col    <= 9'(i_item.first_col);
            r_back   <= i_item.col_count[7];
            r_left   <= n_sat;
            r_fg     <= i_item.fg_colour;
            r_bg     <= i_item.bg_colour;
            r_dfg    <= i_item.draw_fg;
            r_dbg    <= i_item.draw_bg;
            r_dy_rel <= 12'(dy_u - {4'b0, r_clip_y});
        end
        if (r_state == ST_SETUP) begin
            r_base <= prod[23:0];
        end
        if (r_state == ST_WALK) begin
            r_x    <= r_x + 17'sd1;
            r_col  <= r_back ? r_col - 9'sd1 : r_col + 9'sd1;
            r_left <= r_left - NW'(1);
            if (hit) begin
                r_pend_idx <= pix_idx;
                r_pend_val <= pix_val;
                r_out      <= '{pixel_index: r_pend_idx, pixel_value: r_pend_val,
                                last_write: 1'b0};
            end
        end
        if (r_state == ST_FLUSH) begin
            r_out <= '{pixel_index: r_pend_idx, pixel_value: r_pend_val, last_write: 1'b1};
        end
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_res_strobe = r_out_vld;
    assign o_result     = r_out;

    `GRB_ASSERT_NOW(a_pend_in_walk, i_clk, i_rst_n, r_pend_vld,
        (r_state == ST_WALK) || (r_state == ST_FLUSH), "held write outside a row walk")
    `GRB_ASSERT_NOW(a_last_ends_row, i_clk, i_rst_n, o_res_strobe && o_result.last_write,
        r_state == ST_IDLE, "final transfer while the row is still active")
    `GRB_ASSERT_NOW(a_strobe_from_work, i_clk, i_rst_n, o_res_strobe,
        $past(r_state == ST_WALK) || $past(r_state == ST_FLUSH),
        "transfer without a walking row")
    `GRB_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, r_state == ST_FLUSH,
        !r_pend_vld, "held write survives the flush")

endmodule
